@@ src/skf_pkg.sv @@
// shared constants and types of the scalar kalman filter unit
package skf_pkg;

  localparam int COV_FRAC_BITS = 30;
  localparam int DATA_W        = 32;
  localparam int GAIN_W        = COV_FRAC_BITS + 1;
  localparam int CNT_W         = $clog2(GAIN_W);
  localparam int MAG_W         = DATA_W + 1;
  localparam int REM_W         = DATA_W + 2;
  localparam int PE_W          = MAG_W + GAIN_W;
  localparam int PC_W          = DATA_W + GAIN_W;
  localparam int IDX_W         = 2;

  localparam logic [DATA_W-1:0] COV_ONE   = DATA_W'(1) << COV_FRAC_BITS;
  localparam logic [GAIN_W-1:0] GAIN_ONE  = GAIN_W'(1) << COV_FRAC_BITS;
  localparam logic [DATA_W-1:0] Q_RESET   = DATA_W'(10737);
  localparam logic [DATA_W-1:0] R_RESET   = DATA_W'(3135326);
  localparam logic [CNT_W-1:0]  CNT_LAST  = CNT_W'(COV_FRAC_BITS);

  typedef enum logic [IDX_W-1:0] {
    REG_PROCESS_NOISE    = 2'd0,
    REG_MEASURE_NOISE    = 2'd1,
    REG_START_COVARIANCE = 2'd2,
    REG_START_ESTIMATE   = 2'd3
  } reg_index_t;

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_PREP = 7'b0000010,
    ST_DIV  = 7'b0000100,
    ST_MSET = 7'b0001000,
    ST_MUL  = 7'b0010000,
    ST_WB   = 7'b0100000,
    ST_FIN  = 7'b1000000
  } state_t;

endpackage

@@ src/scalar_kalman_filter_unit.sv @@
// scalar kalman filter unit: bit-serial gain divider and covariance/estimate multipliers
//
// Input channel (in_valid/in_ready) carries one request: action and measurement.
// action 0 runs a filter update with the measurement, action 1 reloads the
// estimate and covariance from start_estimate and start_covariance.
// Output channel (out_valid/out_ready) returns one result per request: the new
// estimate and the gain of the step (zero on restart).
// Configuration is written through cfg_wen/cfg_index/cfg_data while idle; the unit
// does not enforce this, the user must keep to it.
// An update runs from acceptance to out_valid through ST_PREP, which sets up
// the divider, ST_DIV, a restoring division for the gain (one quotient bit
// a cycle), ST_MSET, which loads the multipliers, ST_MUL, shift-add
// multiplication (one gain bit a cycle, estimate and covariance products side
// by side), the write-back in ST_WB and ST_FIN, which fills the output register.
// A restart goes from acceptance through ST_FIN into the output register.
// No new request is taken before the last one is through, as in_ready is high whenever
// no request is in work; that holds while a finished result still waits in the output
// register. If the receiver stalls, the next result waits in the unit until it frees.
// Synchronous reset sets the covariance to 1.0, the estimate to zero and the
// noise registers to their defaults, and empties the output register.
module scalar_kalman_filter_unit
  import skf_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     action,
  input  logic signed [DATA_W-1:0] measurement,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [DATA_W-1:0] estimate,
  output logic        [GAIN_W-1:0] gain,
  input  logic                     cfg_wen,
  input  logic        [IDX_W-1:0]  cfg_index,
  input  logic        [DATA_W-1:0] cfg_data
);

  state_t state;

  logic [DATA_W-1:0]        process_noise;
  logic [DATA_W-1:0]        measure_noise;
  logic [DATA_W-1:0]        start_covariance;
  logic signed [DATA_W-1:0] start_estimate;

  logic [DATA_W-1:0]        cov;
  logic signed [DATA_W-1:0] x_est;

  logic [DATA_W-1:0]        p1;
  logic signed [MAG_W-1:0]  innov;
  logic                     neg;
  logic [MAG_W-1:0]         mag;
  logic [MAG_W-1:0]         denom;
  logic                     dz;
  logic [REM_W-1:0]         rem;
  logic [GAIN_W-1:0]        quo;
  logic [GAIN_W-1:0]        k;
  logic [CNT_W-1:0]         cnt;
  logic [PE_W-1:0]          prod_e;
  logic [PC_W-1:0]          prod_c;

  logic                     accept;
  logic                     out_free;
  logic [MAG_W-1:0]         p1_sum;
  logic [MAG_W-1:0]         denom_sum;
  logic [REM_W-1:0]         rem_sh;
  logic [REM_W:0]           trial;
  logic                     ge;
  logic [GAIN_W-1:0]        k_fin;
  logic [REM_W-1:0]         sum_e;
  logic [MAG_W-1:0]         sum_c;
  logic [REM_W-1:0]         delta;
  logic signed [REM_W:0]    x_ext;
  logic signed [REM_W:0]    x_sum;
  logic signed [DATA_W-1:0] x_sat;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  always_comb begin
    p1_sum    = {1'b0, cov} + {1'b0, process_noise};
    denom_sum = {1'b0, p1} + {1'b0, measure_noise};
    // dividend bits below the initial remainder: lowest bit of p1, then zeros
    rem_sh    = {rem[REM_W-2:0], (cnt == '0) ? p1[0] : 1'b0};
    trial     = {1'b0, rem_sh} - {2'b00, denom};
    ge        = !trial[REM_W];
    k_fin     = dz ? '0 : quo;
    sum_e     = {1'b0, prod_e[PE_W-1:GAIN_W]} + (prod_e[0] ? {1'b0, mag} : '0);
    sum_c     = {1'b0, prod_c[PC_W-1:GAIN_W]} + (prod_c[0] ? {1'b0, p1} : '0);
    delta     = prod_e[PE_W-1:COV_FRAC_BITS];
    x_ext     = {{(REM_W+1-DATA_W){x_est[DATA_W-1]}}, x_est};
    x_sum     = neg ? (x_ext - $signed({1'b0, delta})) : (x_ext + $signed({1'b0, delta}));
    // saturate to the signed estimate range
    if (!x_sum[REM_W] && (x_sum[REM_W-1:DATA_W-1] != '0)) begin
      x_sat = {1'b0, {(DATA_W-1){1'b1}}};
    end else if (x_sum[REM_W] && (x_sum[REM_W-1:DATA_W-1] != '1)) begin
      x_sat = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      x_sat = x_sum[DATA_W-1:0];
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      process_noise    <= Q_RESET;
      measure_noise    <= R_RESET;
      start_covariance <= COV_ONE;
      start_estimate   <= '0;
    end else if (cfg_wen) begin
      case (reg_index_t'(cfg_index))
        REG_PROCESS_NOISE:    process_noise    <= cfg_data;
        REG_MEASURE_NOISE:    measure_noise    <= cfg_data;
        REG_START_COVARIANCE: start_covariance <= cfg_data;
        REG_START_ESTIMATE:   start_estimate   <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer and filter state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cov   <= COV_ONE;
      x_est <= '0;
      k     <= '0;
      cnt   <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept) begin
            if (action) begin
              cov   <= start_covariance;
              x_est <= start_estimate;
              k     <= '0;
              state <= ST_FIN;
            end else begin
              state <= ST_PREP;
            end
          end
        end
        ST_PREP: begin
          cnt   <= '0;
          state <= ST_DIV;
        end
        ST_DIV: begin
          if (cnt == CNT_LAST) begin
            state <= ST_MSET;
          end
          cnt <= cnt + CNT_W'(1);
        end
        ST_MSET: begin
          k     <= k_fin;
          cnt   <= '0;
          state <= ST_MUL;
        end
        ST_MUL: begin
          if (cnt == CNT_LAST) begin
            state <= ST_WB;
          end
          cnt <= cnt + CNT_W'(1);
        end
        ST_WB: begin
          x_est <= x_sat;
          cov   <= prod_c[DATA_W+COV_FRAC_BITS-1:COV_FRAC_BITS];
          state <= ST_FIN;
        end
        ST_FIN: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // datapath shift registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (accept) begin
          p1    <= p1_sum[MAG_W-1] ? '1 : p1_sum[DATA_W-1:0];
          innov <= $signed({measurement[DATA_W-1], measurement})
                 - $signed({x_est[DATA_W-1], x_est});
        end
      end
      ST_PREP: begin
        denom <= denom_sum;
        dz    <= (denom_sum == '0);
        rem   <= {3'b000, p1[DATA_W-1:1]};
        quo   <= '0;
        neg   <= innov[MAG_W-1];
        mag   <= innov[MAG_W-1] ? MAG_W'(-innov) : MAG_W'(innov);
      end
      ST_DIV: begin
        rem <= ge ? trial[REM_W-1:0] : rem_sh;
        quo <= {quo[GAIN_W-2:0], ge};
      end
      ST_MSET: begin
        prod_e <= {{MAG_W{1'b0}}, k_fin};
        prod_c <= {{DATA_W{1'b0}}, GAIN_ONE - k_fin};
      end
      ST_MUL: begin
        prod_e <= {sum_e, prod_e[GAIN_W-1:1]};
        prod_c <= {sum_c, prod_c[GAIN_W-1:1]};
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == ST_FIN) && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_FIN) && out_free) begin
      estimate <= x_est;
      gain     <= k;
    end
  end

endmodule

@@ src/skf_checker.sv @@
// port-level checks of the scalar kalman filter unit
module skf_checker
  import skf_pkg::*;
(
  input logic                     clk,
  input logic                     rst,
  input logic                     in_valid,
  input logic                     in_ready,
  input logic                     action,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic        [GAIN_W-1:0] gain
);

  // an update keeps the unit busy for the next cycle
  a_update_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && !action) |=> !in_ready)
    else $error("unit ready right after taking an update");

  // a restart taken while the output is free leaves the unit busy in ST_FIN, then its result is offered
  a_restart_result: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && action && (!out_valid || out_ready)) |=> ##1 (out_valid && gain == '0))
    else $error("restart result missing or gain not zero");

  // gain never exceeds one
  a_gain_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (gain <= GAIN_ONE))
    else $error("gain above one");

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(gain)))
    else $error("result dropped while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result offered after reset");

endmodule

bind scalar_kalman_filter_unit skf_checker u_skf_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .action    (action),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .gain      (gain)
);

@@ test/tb_top.sv @@
// self-checking testbench of the scalar kalman filter unit
module tb_top;
  import skf_pkg::*;

  localparam logic ACT_UPDATE  = 1'b0;
  localparam logic ACT_RESTART = 1'b1;
  localparam int   CYCLE_LIMIT = 500000;
  localparam int   ROUNDS      = 8;
  localparam int   ROUND_ITEMS = 60;
  localparam logic [63:0] GAIN_LIM = (64'd1 << GAIN_W) - 64'd1;
  localparam logic [63:0] ONE_WIDE = 64'd1 << COV_FRAC_BITS;

  typedef struct packed {
    logic [DATA_W-1:0] est;
    logic [GAIN_W-1:0] gain;
  } update_t;

  logic                     clk         = 1'b0;
  logic                     rst         = 1'b1;
  logic                     in_valid    = 1'b0;
  logic                     in_ready;
  logic                     action      = ACT_UPDATE;
  logic signed [DATA_W-1:0] measurement = '0;
  logic                     out_valid;
  logic                     out_ready   = 1'b0;
  logic signed [DATA_W-1:0] estimate;
  logic        [GAIN_W-1:0] gain;
  logic                     cfg_wen     = 1'b0;
  logic        [IDX_W-1:0]  cfg_index   = '0;
  logic        [DATA_W-1:0] cfg_data    = '0;

  // filter state and settings as the unit should hold them
  logic [DATA_W-1:0] q_noise   = Q_RESET;
  logic [DATA_W-1:0] r_noise   = R_RESET;
  logic [DATA_W-1:0] start_cov = COV_ONE;
  logic [DATA_W-1:0] start_est = '0;
  logic [DATA_W-1:0] model_cov = COV_ONE;
  logic [DATA_W-1:0] model_est = '0;

  update_t awaited_updates[$];
  int      mismatches = 0;
  int      cycles     = 0;
  bit      idle_on    = 1'b0;
  int      hold_len   = 0;
  int      stall_left = 0;

  scalar_kalman_filter_unit i_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .action      (action),
    .measurement (measurement),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .estimate    (estimate),
    .gain        (gain),
    .cfg_wen     (cfg_wen),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic update_t kalman_step(input logic act, input logic [DATA_W-1:0] meas);
    logic [63:0] p1;
    logic [63:0] den;
    logic [63:0] k;
    logic [63:0] mag;
    logic [63:0] delta;
    logic [63:0] prod;
    logic signed [63:0] innov;
    logic signed [63:0] xnew;
    update_t res;
    if (act == ACT_RESTART) begin
      model_cov = start_cov;
      model_est = start_est;
      res.est = model_est;
      res.gain = '0;
      return res;
    end
    p1 = {32'd0, model_cov} + {32'd0, q_noise};
    if (p1 > 64'hFFFF_FFFF) p1 = 64'hFFFF_FFFF;
    den = p1 + {32'd0, r_noise};
    k = (den == 64'd0) ? 64'd0 : (p1 << COV_FRAC_BITS) / den;
    if (k > GAIN_LIM) k = GAIN_LIM;
    // innovation needs 33 bits, magnitude times gain truncates toward zero
    innov = $signed({{32{meas[31]}}, meas}) - $signed({{32{model_est[31]}}, model_est});
    mag = innov[63] ? $unsigned(-innov) : $unsigned(innov);
    delta = (k * mag) >> COV_FRAC_BITS;
    xnew = $signed({{32{model_est[31]}}, model_est})
         + (innov[63] ? -$signed(delta) : $signed(delta));
    if (xnew > $signed(64'h0000_0000_7FFF_FFFF)) xnew = $signed(64'h0000_0000_7FFF_FFFF);
    if (xnew < $signed(64'hFFFF_FFFF_8000_0000)) xnew = $signed(64'hFFFF_FFFF_8000_0000);
    model_est = xnew[31:0];
    prod = ((ONE_WIDE - k) * p1) >> COV_FRAC_BITS;
    model_cov = prod[31:0];
    res.est = model_est;
    res.gain = k[GAIN_W-1:0];
    return res;
  endfunction

  task automatic flag_mismatch(input string msg);
    if (mismatches < 10) $display("mismatch: %s", msg);
    mismatches++;
  endtask

  // receiver: random stall after each result while idle_on is set, plus a long hold-off on demand
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_len > 0) begin
      out_ready <= 1'b0;
      hold_len = hold_len - 1;
    end else if (out_valid && out_ready) begin
      stall_left = idle_on ? $urandom_range(0, 17) : 0;
      out_ready <= (stall_left == 0);
    end else if (stall_left > 0) begin
      stall_left = stall_left - 1;
      out_ready <= (stall_left == 0);
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    update_t want;
    if (!rst && out_valid && out_ready) begin
      if (awaited_updates.size() == 0) begin
        flag_mismatch($sformatf("unexpected result est=%h gain=%h", estimate, gain));
      end else begin
        want = awaited_updates.pop_front();
        if (estimate !== want.est || gain !== want.gain)
          flag_mismatch($sformatf("expected est=%h gain=%h, got est=%h gain=%h",
                                  want.est, want.gain, estimate, gain));
      end
    end
  end

  // in_valid stays high when the next request follows without a gap
  task automatic send_request(input logic act, input logic [DATA_W-1:0] meas);
    int gap;
    gap = idle_on ? $urandom_range(0, 17) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    action      <= act;
    measurement <= meas;
    do @(posedge clk); while (!in_ready);
    awaited_updates.push_back(kalman_step(act, meas));
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (awaited_updates.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic load_settings(input logic [DATA_W-1:0] q, input logic [DATA_W-1:0] r,
                               input logic [DATA_W-1:0] pc, input logic [DATA_W-1:0] pe);
    logic [DATA_W-1:0] vals [4];
    reg_index_t idx;
    vals[REG_PROCESS_NOISE]    = q;
    vals[REG_MEASURE_NOISE]    = r;
    vals[REG_START_COVARIANCE] = pc;
    vals[REG_START_ESTIMATE]   = pe;
    idx = idx.first();
    repeat (4) begin
      cfg_wen   <= 1'b1;
      cfg_index <= idx;
      cfg_data  <= vals[idx];
      @(posedge clk);
      idx = idx.next();
    end
    cfg_wen <= 1'b0;
    q_noise   = q;
    r_noise   = r;
    start_cov = pc;
    start_est = pe;
  endtask

  function automatic logic [DATA_W-1:0] pick_cov_value();
    case ($urandom_range(0, 4))
      0: return $urandom_range(0, 1 << 20);
      1: return $urandom;
      2: return $urandom_range(0, 1 << 31);
      3: return COV_ONE;
      default: return ($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF : 32'd0;
    endcase
  endfunction

  function automatic logic [DATA_W-1:0] pick_measurement();
    case ($urandom_range(0, 5))
      0, 1: return $urandom;
      2: return model_est + $urandom_range(0, 1 << 20) - (1 << 19);
      3: begin
        case ($urandom_range(0, 3))
          0: return 32'h7FFF_FFFF;
          1: return 32'h8000_0000;
          2: return 32'h0000_0000;
          default: return 32'hFFFF_FFFF;
        endcase
      end
      default: return model_est + ($urandom & 32'h00FF_FFFF) - 32'h0080_0000;
    endcase
  endfunction

  task automatic test_reset_state();
    send_request(ACT_UPDATE, 32'h0000_0000);
    send_request(ACT_UPDATE, 32'h7FFF_FFFF);
    send_request(ACT_UPDATE, 32'h8000_0000);
    send_request(ACT_UPDATE, 32'hFFFF_FFFF);
    send_request(ACT_UPDATE, 32'h0001_0000);
    send_request(ACT_RESTART, 32'h1234_5678);
    send_request(ACT_UPDATE, 32'h7FFF_FFFF);
    settle();
  endtask

  // all noise and covariance zero: gain zero, state must not move
  task automatic test_zero_denominator();
    load_settings(32'd0, 32'd0, 32'd0, 32'h0001_0000);
    send_request(ACT_RESTART, 32'hFFFF_FFFF);
    send_request(ACT_UPDATE, 32'h7FFF_FFFF);
    send_request(ACT_UPDATE, 32'h8000_0000);
    settle();
  endtask

  task automatic test_saturation();
    load_settings(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
    send_request(ACT_RESTART, 32'd0);
    send_request(ACT_UPDATE, 32'h8000_0000);
    send_request(ACT_UPDATE, 32'h7FFF_FFFF);
    settle();
    // no measurement noise: gain at one, estimate jumps to the measurement
    load_settings(32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF, 32'h8000_0000);
    send_request(ACT_RESTART, 32'h5555_5555);
    send_request(ACT_UPDATE, 32'h7FFF_FFFF);
    send_request(ACT_UPDATE, 32'h0000_0000);
    send_request(ACT_UPDATE, 32'hAAAA_AAAA);
    settle();
  endtask

  task automatic test_output_backpressure();
    load_settings(Q_RESET, R_RESET, COV_ONE, 32'd0);
    idle_on = 1'b0;
    hold_len = 500;
    repeat (12) send_request(ACT_UPDATE, pick_measurement());
    settle();
  endtask

  task automatic test_random_rounds();
    for (int round = 0; round < ROUNDS; round++) begin
      if (round == 0)
        load_settings(Q_RESET, R_RESET, COV_ONE, 32'd0);
      else
        load_settings(pick_cov_value(), pick_cov_value(), pick_cov_value(), $urandom);
      idle_on = (round % 4) != 3;
      for (int n = 0; n < ROUND_ITEMS; n++) begin
        if ($urandom_range(0, 9) == 0)
          send_request(ACT_RESTART, $urandom);
        else
          send_request(ACT_UPDATE, pick_measurement());
      end
      settle();
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    idle_on = 1'b1;
    test_reset_state();
    test_zero_denominator();
    test_saturation();
    test_output_backpressure();
    test_random_rounds();
    settle();
    repeat (80) @(posedge clk);
    if (awaited_updates.size() != 0)
      flag_mismatch($sformatf("%0d results never arrived", awaited_updates.size()));
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
